[rtl/cms_pkg.sv]
// ----------------------------------------------------------------------------
// cms_pkg
// Shared widths, constants and controller/datapath types for channel_mean_sigma.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int CHANNEL_BITS = 10;
    localparam int ADC_BITS     = 12;
    localparam int MAX_SAMPLES  = 16384;

    localparam int COUNT_W  = 15;
    localparam int SUM_W    = 26;
    localparam int SQSUM_W  = 38;
    localparam int MEAN_W   = 20;
    localparam int SIGMA_W  = 20;

    localparam int PROD_W   = 53;   // n * sum of squares, sum * sum
    localparam int NUM_W    = 35;   // 256 * sum + n / 2
    localparam int DVS_W    = 29;   // n * n
    localparam int QUO_W    = 38;   // 65536 * variance
    localparam int SHIFT_FRAC = 16;

    localparam int MEAN_STEPS  = 20;
    localparam int SIGMA_STEPS = 38;
    localparam int SQRT_STEPS  = 19;
    localparam int STEP_W      = 6;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic       REG_SELECTED_CHANNEL = 1'b0;
    localparam logic [CHANNEL_BITS-1:0] SEL_RESET = CHANNEL_BITS'(10);

    typedef struct packed {
        logic acc_en;
        logic snap;
        logic mul;
        logic sub;
        logic load_mean;
        logic div_step;
        logic save_mean;
        logic load_sigma;
        logic sqrt_load;
        logic sqrt_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
    } t_dp_sts;

endpackage

[rtl/cms_ctrl.sv]
// ----------------------------------------------------------------------------
// cms_ctrl
// Sequencer: accepts samples, steps the per-event arithmetic, owns output valid.
// ----------------------------------------------------------------------------
module cms_ctrl
    import cms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_sample,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_DIVM,
        ST_LOADS,
        ST_DIVS,
        ST_SQL,
        ST_SQRT
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_out_valid;
    logic                r_done;
    logic                in_acc;
    logic                out_free;

    assign in_acc   = (r_state == ST_IDLE) && !r_done && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd        = '0;
        o_cmd.acc_en = in_acc;
        o_cmd.snap   = in_acc && i_last_sample;
        o_cmd.load_out = r_done && out_free;
        unique case (r_state)
            ST_IDLE:  ;
            ST_MUL:   o_cmd.mul = 1'b1;
            ST_SUB: begin
                o_cmd.sub       = 1'b1;
                o_cmd.load_mean = 1'b1;
            end
            ST_DIVM:  o_cmd.div_step = 1'b1;
            ST_LOADS: begin
                o_cmd.save_mean  = 1'b1;
                o_cmd.load_sigma = 1'b1;
            end
            ST_DIVS:  o_cmd.div_step  = 1'b1;
            ST_SQL:   o_cmd.sqrt_load = 1'b1;
            ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            default:  ;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE) || r_done;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_done      <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.snap) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (i_sts.empty) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIVM;
                end
                ST_DIVM: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(MEAN_STEPS - 1)) begin
                        r_state <= ST_LOADS;
                    end
                end
                ST_LOADS: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIVS;
                end
                ST_DIVS: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(SIGMA_STEPS - 1)) begin
                        r_state <= ST_SQL;
                    end
                end
                ST_SQL: begin
                    r_cnt   <= '0;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/cms_dp.sv]
// ----------------------------------------------------------------------------
// cms_dp
// Datapath: accumulators, products, shared restoring divider, bit-pair square
// root and the result register.
// ----------------------------------------------------------------------------
module cms_dp
    import cms_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [CHANNEL_BITS-1:0] i_sel_channel,
    input  logic [CHANNEL_BITS-1:0] i_channel_id,
    input  logic [ADC_BITS-1:0]     i_amplitude,
    output t_dp_sts                 o_sts,
    output logic [MEAN_W-1:0]       o_mean_value,
    output logic [SIGMA_W-1:0]      o_sigma_value,
    output logic [COUNT_W-1:0]      o_sample_count,
    output logic                    o_empty_event
);

    logic [COUNT_W-1:0]  r_acc_n;
    logic [SUM_W-1:0]    r_acc_s;
    logic [SQSUM_W-1:0]  r_acc_q;
    logic [COUNT_W-1:0]  n_acc_n;
    logic [SUM_W-1:0]    n_acc_s;
    logic [SQSUM_W-1:0]  n_acc_q;
    logic                take;
    logic [2*ADC_BITS-1:0] amp_sq;

    logic [COUNT_W-1:0]  r_n;
    logic [SUM_W-1:0]    r_s;
    logic [SQSUM_W-1:0]  r_q;

    logic [PROD_W-1:0]   r_pa;
    logic [PROD_W-1:0]   r_pb;
    logic [DVS_W-1:0]    r_nn;
    logic [NUM_W-1:0]    r_mnum;
    logic [PROD_W-1:0]   r_diff;
    logic [2*COUNT_W-1:0] nn_full;

    logic [DVS_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_dsh;
    logic [DVS_W-1:0]    r_dvs;
    logic [QUO_W-1:0]    r_quo;
    logic [DVS_W:0]      div_t;
    logic [DVS_W:0]      div_d;
    logic                div_ge;

    logic [MEAN_W-1:0]   r_mean;
    logic [QUO_W-1:0]    r_sv;
    logic [QUO_W-1:0]    r_sres;
    logic [QUO_W-1:0]    r_sbit;
    logic [QUO_W-1:0]    sq_sum;

    assign take = (i_channel_id == i_sel_channel) && (r_acc_n < COUNT_W'(MAX_SAMPLES));
    assign amp_sq = i_amplitude * i_amplitude;

    always_comb begin
        n_acc_n = r_acc_n;
        n_acc_s = r_acc_s;
        n_acc_q = r_acc_q;
        if (i_cmd.acc_en && take) begin
            n_acc_n = r_acc_n + 1'b1;
            n_acc_s = r_acc_s + SUM_W'(i_amplitude);
            n_acc_q = r_acc_q + SQSUM_W'(amp_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_n <= '0;
            r_acc_s <= '0;
            r_acc_q <= '0;
        end else if (i_cmd.snap) begin
            r_acc_n <= '0;
            r_acc_s <= '0;
            r_acc_q <= '0;
        end else begin
            r_acc_n <= n_acc_n;
            r_acc_s <= n_acc_s;
            r_acc_q <= n_acc_q;
        end
    end

    assign o_sts.empty = (r_n == '0);
    assign nn_full     = (2*COUNT_W)'(r_n) * (2*COUNT_W)'(r_n);

    // divider: remainder stays below the divisor, one quotient bit per step
    assign div_t  = {r_rem, r_dsh[QUO_W-1]};
    assign div_d  = {1'b0, r_dvs};
    assign div_ge = (div_t >= div_d);

    assign sq_sum = r_sres + r_sbit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_n <= n_acc_n;
            r_s <= n_acc_s;
            r_q <= n_acc_q;
        end
        if (i_cmd.mul) begin
            r_pa   <= PROD_W'(r_n) * PROD_W'(r_q);
            r_pb   <= PROD_W'(r_s) * PROD_W'(r_s);
            r_nn   <= nn_full[DVS_W-1:0];
            r_mnum <= NUM_W'({r_s, 8'b0}) + NUM_W'(r_n >> 1);
        end
        if (i_cmd.sub) begin
            r_diff <= (r_pa >= r_pb) ? (r_pa - r_pb) : '0;
        end
        if (i_cmd.load_mean) begin
            r_rem <= DVS_W'(r_mnum[NUM_W-1:MEAN_STEPS]);
            r_dsh <= {r_mnum[MEAN_STEPS-1:0], (QUO_W-MEAN_STEPS)'(0)};
            r_dvs <= DVS_W'(r_n);
            r_quo <= '0;
        end else if (i_cmd.load_sigma) begin
            r_rem <= r_diff[QUO_W-SHIFT_FRAC+DVS_W-1:QUO_W-SHIFT_FRAC];
            r_dsh <= {r_diff[QUO_W-SHIFT_FRAC-1:0], SHIFT_FRAC'(0)};
            r_dvs <= r_nn;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? DVS_W'(div_t - div_d) : div_t[DVS_W-1:0];
            r_dsh <= r_dsh << 1;
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
        end
        if (i_cmd.save_mean) begin
            r_mean <= r_quo[MEAN_W-1:0];
        end
        if (i_cmd.sqrt_load) begin
            r_sv   <= r_quo;
            r_sres <= '0;
            r_sbit <= QUO_W'(1) << (2*(SQRT_STEPS-1));
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= sq_sum) begin
                r_sv   <= r_sv - sq_sum;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.load_out) begin
            o_empty_event  <= o_sts.empty;
            o_sample_count <= r_n;
            o_mean_value   <= o_sts.empty ? '0 : r_mean;
            o_sigma_value  <= o_sts.empty ? '0 : r_sres[SIGMA_W-1:0];
        end
    end

endmodule

[rtl/channel_mean_sigma.sv]
// ----------------------------------------------------------------------------
// channel_mean_sigma
// Per-event mean and population standard deviation of one selected channel.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one detector sample per request,
// channel id, ADC amplitude and an end-of-event mark. Samples of the channel
// set in selected_channel (APB register at 0x0, reset 10) are counted and
// summed, up to 16384 per event. Within an event a sample is taken every
// cycle.
// On the request that carries i_last_sample the event closes: the input
// stalls while the sequencer runs a product stage, a 20-step divide for the
// mean, a 38-step divide for the variance and a 19-step square root, all on
// one shared divider and one root unit. An event with no matching sample
// skips the divides and the root. The next sample is taken at the earliest
// in the same cycle that the result appears.
// Output channel (o_out_valid / i_out_stall): one request per event, held
// in an output register; a stalled result stays put while the next event
// accumulates. A finished event waits for that register to free up.
// Reset clears the accumulators, the output valid and the sequencer, and
// sets selected_channel back to 10.
// ----------------------------------------------------------------------------
module channel_mean_sigma
    import cms_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CHANNEL_BITS-1:0] i_channel_id,
    input  logic [ADC_BITS-1:0]     i_amplitude,
    input  logic                    i_last_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [MEAN_W-1:0]       o_mean_value,
    output logic [SIGMA_W-1:0]      o_sigma_value,
    output logic [COUNT_W-1:0]      o_sample_count,
    output logic                    o_empty_event
);

    logic [CHANNEL_BITS-1:0] r_sel_channel;
    logic                    reg_hit;
    t_dp_cmd                 cmd;
    t_dp_sts                 sts;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_SELECTED_CHANNEL);
    assign prdata  = reg_hit ? PDATA_W'(r_sel_channel) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_channel <= SEL_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_sel_channel <= pwdata[CHANNEL_BITS-1:0];
        end
    end

    cms_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .i_out_stall   (i_out_stall),
        .i_sts         (sts),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_cmd         (cmd)
    );

    cms_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sel_channel  (r_sel_channel),
        .i_channel_id   (i_channel_id),
        .i_amplitude    (i_amplitude),
        .o_sts          (sts),
        .o_mean_value   (o_mean_value),
        .o_sigma_value  (o_sigma_value),
        .o_sample_count (o_sample_count),
        .o_empty_event  (o_empty_event)
    );

endmodule

[rtl/cms_checker.sv]
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks for channel_mean_sigma, bound to the top level.
// ----------------------------------------------------------------------------
module cms_checker
    import cms_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_last_sample,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [MEAN_W-1:0]       o_mean_value,
    input logic [SIGMA_W-1:0]      o_sigma_value,
    input logic [COUNT_W-1:0]      o_sample_count,
    input logic                    o_empty_event
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mean_value)
            && $stable(o_sigma_value) && $stable(o_sample_count)
            && $stable(o_empty_event))
        else $error("stalled request changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_event |-> o_mean_value == '0
            && o_sigma_value == '0 && o_sample_count == '0)
        else $error("empty event with nonzero fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_empty_event |-> o_sample_count != '0
            && o_sample_count <= COUNT_W'(MAX_SAMPLES))
        else $error("sample count out of range");

    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_sample |=> o_in_stall)
        else $error("input not stalled after event end");

endmodule

bind channel_mean_sigma cms_checker u_cms_checker (.*);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for channel_mean_sigma. Streams detector samples in
// events through the valid/stall input, folds every accepted sample into a
// fixed-point mean/sigma tracker and compares each result request field by
// field. Covers directed corner events, random events under several channel
// selections (including a change in the middle of an event) and output
// back-pressure that fills the block.
// ----------------------------------------------------------------------------
module testbench;
    import cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_INDEX_UNMAPPED = 1;
    localparam logic [PADDR_W-1:0] ADDR_SELECTED_CHANNEL =
        PADDR_W'(4 * int'(REG_SELECTED_CHANNEL));
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4 * REG_INDEX_UNMAPPED);
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;
    localparam logic [ADC_BITS-1:0]     AMP_MAX  = '1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] chan;
        logic [ADC_BITS-1:0]     amp;
        logic                    last;
    } t_sample;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean;
        logic [SIGMA_W-1:0] sigma;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_stats;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    class mean_sigma_tracker;
        logic [CHANNEL_BITS-1:0] sel_chan;
        logic [SUM_W-1:0]        amp_sum;
        logic [SQSUM_W-1:0]      sq_sum;
        logic [COUNT_W-1:0]      n_match;
        t_stats                  awaited_stats[$];
        int                      errors;

        function new();
            sel_chan = SEL_RESET;
            amp_sum  = '0;
            sq_sum   = '0;
            n_match  = '0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return awaited_stats.size();
        endfunction

        function void take_sample(t_sample s);
            t_stats r;
            logic [127:0] prod_n, prod_s, spread, quot;
            logic [63:0]  rad, root, probe;
            if (s.chan == sel_chan && int'(n_match) < MAX_SAMPLES) begin
                n_match = n_match + 1'b1;
                amp_sum = amp_sum + SUM_W'(s.amp);
                sq_sum  = sq_sum + SQSUM_W'(s.amp) * SQSUM_W'(s.amp);
            end
            if (!s.last) return;
            r = '0;
            if (n_match == 0) begin
                r.empty = 1'b1;
            end else begin
                r.mean = MEAN_W'((128'(amp_sum) * 256 + 128'(n_match) / 2) / 128'(n_match));
                prod_n = 128'(n_match) * 128'(sq_sum);
                prod_s = 128'(amp_sum) * 128'(amp_sum);
                spread = (prod_n >= prod_s) ? (prod_n - prod_s) : '0;
                quot   = (spread << SHIFT_FRAC) / (128'(n_match) * 128'(n_match));
                rad    = quot[63:0];
                root   = '0;
                probe  = 64'h4000_0000_0000_0000;
                while (probe > rad) probe = probe >> 2;
                while (probe != 0) begin
                    if (rad >= root + probe) begin
                        rad  = rad - (root + probe);
                        root = (root >> 1) + probe;
                    end else begin
                        root = root >> 1;
                    end
                    probe = probe >> 2;
                end
                r.sigma = SIGMA_W'(root);
                r.count = n_match;
            end
            awaited_stats.push_back(r);
            amp_sum = '0;
            sq_sum  = '0;
            n_match = '0;
        endfunction

        task match_stats(t_stats got);
            t_stats want;
            if (awaited_stats.size() == 0) begin
                report($sformatf("result request with nothing expected (mean %0d)", got.mean));
                return;
            end
            want = awaited_stats.pop_front();
            if (got.mean != want.mean)
                report($sformatf("mean_value %0d, expected %0d", got.mean, want.mean));
            if (got.sigma != want.sigma)
                report($sformatf("sigma_value %0d, expected %0d", got.sigma, want.sigma));
            if (got.count != want.count)
                report($sformatf("sample_count %0d, expected %0d", got.count, want.count));
            if (got.empty != want.empty)
                report($sformatf("empty_event %0d, expected %0d", got.empty, want.empty));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [CHANNEL_BITS-1:0] i_channel_id;
    logic [ADC_BITS-1:0]     i_amplitude;
    logic                    i_last_sample;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [MEAN_W-1:0]       o_mean_value;
    logic [SIGMA_W-1:0]      o_sigma_value;
    logic [COUNT_W-1:0]      o_sample_count;
    logic                    o_empty_event;

    mean_sigma_tracker tracker = new();
    t_sample     sample_queue[$];
    int          cycle_count = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          random_items = 0;

    channel_mean_sigma u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_channel_id   (i_channel_id),
        .i_amplitude    (i_amplitude),
        .i_last_sample  (i_last_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mean_value   (o_mean_value),
        .o_sigma_value  (o_sigma_value),
        .o_sample_count (o_sample_count),
        .o_empty_event  (o_empty_event)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise its own stall pattern
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_out_stall <= ((cycle_count % 7) < 3);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.match_stats('{o_mean_value, o_sigma_value, o_sample_count, o_empty_event});
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SELECTED_CHANNEL)
            tracker.sel_chan = data[CHANNEL_BITS-1:0];
        @(posedge i_clk);
    endtask

    task automatic reg_check(input logic [PADDR_W-1:0] addr);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != PDATA_W'(tracker.sel_chan))
            tracker.report($sformatf("selected_channel reads %0d, expected %0d",
                                     got, tracker.sel_chan));
        @(posedge i_clk);
    endtask

    task automatic push_sample(input int chan, input int amp, input bit last);
        sample_queue.push_back('{CHANNEL_BITS'(chan), ADC_BITS'(amp), last});
    endtask

    // one event of random content; close = 0 leaves it open
    task automatic queue_event(input int len, input int match_pct, input bit close);
        logic [CHANNEL_BITS-1:0] chan;
        logic [ADC_BITS-1:0]     amp;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < match_pct)
                chan = tracker.sel_chan;
            else if ($urandom_range(0, 1) == 0)
                chan = tracker.sel_chan ^ CHANNEL_BITS'(1 << $urandom_range(0, CHANNEL_BITS - 1));
            else
                chan = CHANNEL_BITS'($urandom);
            case ($urandom_range(0, 5))
                0:       amp = '0;
                1:       amp = AMP_MAX;
                2:       amp = ADC_BITS'($urandom_range(0, 15));
                3:       amp = ADC_BITS'($urandom_range(4000, 4095));
                default: amp = ADC_BITS'($urandom);
            endcase
            sample_queue.push_back('{chan, amp, close && (k == len - 1)});
        end
    endtask

    task automatic drive_samples();
        t_sample s;
        int      gap;
        while (sample_queue.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            s = sample_queue.pop_front();
            i_in_valid    <= 1'b1;
            i_channel_id  <= s.chan;
            i_amplitude   <= s.amp;
            i_last_sample <= s.last;
            do @(posedge i_clk); while (o_in_stall);
            tracker.take_sample(s);
            burst_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int len;
        int phase_items;
        logic [CHANNEL_BITS-1:0] next_sel;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_channel_id  = '0;
        i_amplitude   = '0;
        i_last_sample = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset channel, empty event, extremes, non-matching last
        reg_check(ADDR_SELECTED_CHANNEL);
        push_sample(11, 100, 1'b1);
        push_sample(10, 0, 1'b1);
        push_sample(10, 4095, 1'b1);
        push_sample(10, 0, 1'b0);
        push_sample(10, 4095, 1'b1);
        push_sample(10, 1, 1'b0);
        push_sample(10, 2, 1'b0);
        push_sample(1023, 4095, 1'b1);
        drive_samples();
        settle();

        reg_write(ADDR_SELECTED_CHANNEL, {22'($urandom), CHAN_MAX});
        reg_check(ADDR_SELECTED_CHANNEL);
        push_sample(1023, 4095, 1'b0);
        push_sample(0, 4095, 1'b0);
        push_sample(1023, 0, 1'b0);
        push_sample(1023, 4095, 1'b1);
        drive_samples();
        settle();

        reg_write(ADDR_SELECTED_CHANNEL, '0);
        reg_write(ADDR_UNMAPPED, PDATA_W'(5));
        reg_check(ADDR_SELECTED_CHANNEL);
        push_sample(0, 123, 1'b0);
        push_sample(1023, 7, 1'b0);
        push_sample(0, 4095, 1'b1);
        drive_samples();
        settle();

        // random phases
        for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
            case (phase % 4)
                1:       next_sel = '0;
                2:       next_sel = CHAN_MAX;
                default: next_sel = CHANNEL_BITS'($urandom);
            endcase
            reg_write(ADDR_SELECTED_CHANNEL, {22'($urandom), next_sel});
            reg_check(ADDR_SELECTED_CHANNEL);
            gaps_on = (phase % 3 != 2);
            if (phase == 1)
                hold_req = 800;
            phase_items = 0;
            while (phase_items < 150) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
                case ($urandom_range(0, 3))
                    0:       queue_event(len, 0, 1'b1);
                    1:       queue_event(len, 30, 1'b1);
                    2:       queue_event(len, 75, 1'b1);
                    default: queue_event(len, 100, 1'b1);
                endcase
                phase_items += len;
            end
            // selection change in the middle of an open event
            if (phase == 2) begin
                queue_event(6, 100, 1'b0);
                drive_samples();
                settle();
                reg_write(ADDR_SELECTED_CHANNEL, PDATA_W'($urandom));
                queue_event(5, 60, 1'b1);
                phase_items += 11;
            end
            drive_samples();
            random_items += phase_items;
            settle();
        end

        if (tracker.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
